/* design/assert_macros.svh */
// Assertion macros used by the top level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent check on the rising clock edge, masked while reset is low
`define CQS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Implication check: when ante holds, cons must hold on the same edge
`define CQS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  `CQS_ASSERT(lbl, clk, rstn, (ante) |-> (cons), msg)
`endif

/* design/cqs_pkg.sv */
// Shared types, constants and arithmetic helpers of the curve segment quad setup
`timescale 1ns / 1ps
package cqs_pkg;

  localparam int FracBits  = 4;
  localparam int ClipShift = 15 - FracBits;
  localparam int DivStages = 17;

  localparam logic [1:0] RegContainerWidth  = 2'd0;
  localparam logic [1:0] RegContainerHeight = 2'd1;
  localparam logic [1:0] RegContainerOffX   = 2'd2;
  localparam logic [1:0] RegContainerOffY   = 2'd3;

  typedef logic signed [17:0] coord_t;

  typedef struct packed {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [15:0] ex;
    logic signed [15:0] ey;
    coord_t             lo_x;
    coord_t             lo_y;
    coord_t             hi_x;
    coord_t             hi_y;
  } bbox_t;

  typedef struct packed {
    logic        neg;
    logic        hsat;
    logic [16:0] rem;
    logic [15:0] low;
  } div_prep_t;

  typedef struct packed {
    logic [3:0]  neg;
    logic [3:0]  hsat;
    logic [5:0]  nsat;
    logic [5:0]  nzero;
    logic [16:0] w;
    logic [16:0] h;
  } side_t;

  function automatic coord_t min3(coord_t a, coord_t b, coord_t c);
    coord_t m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic coord_t max3(coord_t a, coord_t b, coord_t c);
    coord_t m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  // one restoring step: {quotient bit, new remainder}
  function automatic logic [17:0] div_step(logic [16:0] rem, logic [16:0] den, logic b);
    logic [17:0] t;
    logic [17:0] s;
    t = {rem, b};
    s = t - {1'b0, den};
    if (t >= {1'b0, den}) return {1'b1, s[16:0]};
    return {1'b0, t[16:0]};
  endfunction

  // clip: Y = num*2^ClipShift + size*2^14, result = floor(Y/size) - 2^15
  function automatic div_prep_t clip_prep(coord_t edge_v, logic signed [12:0] off,
                                          logic [12:0] size);
    logic [12:0]        sz;
    logic signed [21:0] num;
    logic signed [31:0] y;
    div_prep_t          r;
    sz    = (size == '0) ? 13'd1 : size;
    num   = (22'(off) <<< FracBits) + 22'(edge_v);
    y     = (32'(num) <<< ClipShift) + 32'({sz, 14'b0});
    r.neg  = y[31];
    r.hsat = y[30:16] >= {2'b00, sz};
    r.rem  = {4'b0, y[28:16]};
    r.low  = y[15:0];
    return r;
  endfunction

  function automatic logic [15:0] clip_out(logic neg, logic hsat, logic [15:0] q);
    if (neg)  return 16'h8000;
    if (hsat) return 16'h7FFF;
    return q ^ 16'h8000;
  endfunction

  function automatic logic [15:0] norm_out(logic zero, logic sat, logic [15:0] q);
    if (zero) return 16'h0000;
    if (sat)  return 16'hFFFF;
    return q;
  endfunction

endpackage

/* design/curve_segment_quad_setup_unit.sv */
// Top level of the curve segment quad setup pipeline
//
//  channel | direction | handshake                    | payload
//  --------+-----------+------------------------------+------------------------------
//  in      | input     | in_valid_i / in_stall_o      | start/control/end points, thickness
//  out     | output    | out_valid_o / out_stall_i    | clip quad, box size, norm points
//  cfg     | input     | cfg_valid_i / cfg_ready_o    | cfg_index_i, cfg_data_i
//
//  One segment per cycle unless a held result stalls the pipeline; box stage, 17 divider stages, output register.
//  Latency is set by the 16-bit restoring dividers, one quotient bit per stage.
//  Reset (async, active low) clears valid bits and loads the container registers.
//  A held result with out_stall_i high freezes every stage; in_stall_o follows it.
//  Segments whose box collapses to a point are dropped after the box stage.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module curve_segment_quad_setup_unit import cqs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [12:0]        cfg_data_i,
  // segment in
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] start_x_i,
  input  logic signed [15:0] start_y_i,
  input  logic signed [15:0] control_x_i,
  input  logic signed [15:0] control_y_i,
  input  logic signed [15:0] end_x_i,
  input  logic signed [15:0] end_y_i,
  input  logic [11:0]        start_thickness_i,
  input  logic [11:0]        end_thickness_i,
  // result out
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] quad_left_o,
  output logic signed [15:0] quad_bottom_o,
  output logic signed [15:0] quad_right_o,
  output logic signed [15:0] quad_top_o,
  output logic [16:0]        box_width_o,
  output logic [16:0]        box_height_o,
  output logic [15:0]        norm_start_x_o,
  output logic [15:0]        norm_start_y_o,
  output logic [15:0]        norm_control_x_o,
  output logic [15:0]        norm_control_y_o,
  output logic [15:0]        norm_end_x_o,
  output logic [15:0]        norm_end_y_o
);

  // container registers
  logic [12:0]        cont_w_q, cont_h_q;
  logic signed [12:0] off_x_q, off_y_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cont_w_q <= 13'd1;
      cont_h_q <= 13'd1;
      off_x_q  <= '0;
      off_y_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegContainerWidth:  cont_w_q <= cfg_data_i;
        RegContainerHeight: cont_h_q <= cfg_data_i;
        RegContainerOffX:   off_x_q  <= cfg_data_i;
        RegContainerOffY:   off_y_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // global advance: everything moves unless a finished result is held
  logic out_valid_q;
  logic en;
  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  // stage 1: bounding box
  logic  box_valid;
  bbox_t box;

  cqs_bbox u_bbox (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .en_i              (en),
    .valid_i           (in_valid_i),
    .start_x_i         (start_x_i),
    .start_y_i         (start_y_i),
    .control_x_i       (control_x_i),
    .control_y_i       (control_y_i),
    .end_x_i           (end_x_i),
    .end_y_i           (end_y_i),
    .start_thickness_i (start_thickness_i),
    .end_thickness_i   (end_thickness_i),
    .valid_o           (box_valid),
    .box_o             (box)
  );

  // stage 2: size, collapse check, divider operands
  logic [18:0] w_full, h_full;
  logic [16:0] w, h;
  logic        keep;
  div_prep_t   cp [4];
  logic [16:0] nrem [6];
  logic [16:0] nden [6];
  side_t       side_d;

  function automatic logic [16:0] rel(logic signed [15:0] p, coord_t lo);
    logic [18:0] d;
    d = 19'(p) - 19'(lo);
    return d[16:0];
  endfunction

  always_comb begin
    w_full = 19'(box.hi_x) - 19'(box.lo_x);
    h_full = 19'(box.hi_y) - 19'(box.lo_y);
    w      = w_full[16:0];
    h      = h_full[16:0];
    keep   = box_valid && ((w != '0) || (h != '0));

    cp[0] = clip_prep(box.lo_x, off_x_q, cont_w_q);
    cp[1] = clip_prep(box.lo_y, off_y_q, cont_h_q);
    cp[2] = clip_prep(box.hi_x, off_x_q, cont_w_q);
    cp[3] = clip_prep(box.hi_y, off_y_q, cont_h_q);

    nrem[0] = rel(box.sx, box.lo_x);
    nrem[1] = rel(box.sy, box.lo_y);
    nrem[2] = rel(box.cx, box.lo_x);
    nrem[3] = rel(box.cy, box.lo_y);
    nrem[4] = rel(box.ex, box.lo_x);
    nrem[5] = rel(box.ey, box.lo_y);
    for (int i = 0; i < 6; i++) begin
      nden[i]           = (i % 2 == 0) ? w : h;
      side_d.nsat[i]    = nrem[i] == nden[i];
      side_d.nzero[i]   = nden[i] == '0;
    end
    for (int i = 0; i < 4; i++) begin
      side_d.neg[i]  = cp[i].neg;
      side_d.hsat[i] = cp[i].hsat;
    end
    side_d.w = w;
    side_d.h = h;
  end

  // dividers: four clip edges, six normalized coordinates
  logic [15:0] quo [10];

  cqs_div u_div_left   (.clk_i(clk_i), .en_i(en), .rem_i(cp[0].rem),
                        .den_i({4'b0, (cont_w_q == '0) ? 13'd1 : cont_w_q}),
                        .low_i(cp[0].low), .quo_o(quo[0]));
  cqs_div u_div_bottom (.clk_i(clk_i), .en_i(en), .rem_i(cp[1].rem),
                        .den_i({4'b0, (cont_h_q == '0) ? 13'd1 : cont_h_q}),
                        .low_i(cp[1].low), .quo_o(quo[1]));
  cqs_div u_div_right  (.clk_i(clk_i), .en_i(en), .rem_i(cp[2].rem),
                        .den_i({4'b0, (cont_w_q == '0) ? 13'd1 : cont_w_q}),
                        .low_i(cp[2].low), .quo_o(quo[2]));
  cqs_div u_div_top    (.clk_i(clk_i), .en_i(en), .rem_i(cp[3].rem),
                        .den_i({4'b0, (cont_h_q == '0) ? 13'd1 : cont_h_q}),
                        .low_i(cp[3].low), .quo_o(quo[3]));

  for (genvar n = 0; n < 6; n++) begin : g_norm
    cqs_div u_div_norm (.clk_i(clk_i), .en_i(en), .rem_i(nrem[n]), .den_i(nden[n]),
                        .low_i('0), .quo_o(quo[4+n]));
  end

  // flags and valid ride alongside the dividers
  logic  valid_q [DivStages];
  side_t side_q  [DivStages];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DivStages; k++) valid_q[k] <= 1'b0;
    end else if (en) begin
      valid_q[0] <= keep;
      for (int k = 1; k < DivStages; k++) valid_q[k] <= valid_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_d;
      for (int k = 1; k < DivStages; k++) side_q[k] <= side_q[k-1];
    end
  end

  // output register
  side_t sd;
  assign sd = side_q[DivStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= valid_q[DivStages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      quad_left_o      <= clip_out(sd.neg[0], sd.hsat[0], quo[0]);
      quad_bottom_o    <= clip_out(sd.neg[1], sd.hsat[1], quo[1]);
      quad_right_o     <= clip_out(sd.neg[2], sd.hsat[2], quo[2]);
      quad_top_o       <= clip_out(sd.neg[3], sd.hsat[3], quo[3]);
      box_width_o      <= sd.w;
      box_height_o     <= sd.h;
      norm_start_x_o   <= norm_out(sd.nzero[0], sd.nsat[0], quo[4]);
      norm_start_y_o   <= norm_out(sd.nzero[1], sd.nsat[1], quo[5]);
      norm_control_x_o <= norm_out(sd.nzero[2], sd.nsat[2], quo[6]);
      norm_control_y_o <= norm_out(sd.nzero[3], sd.nsat[3], quo[7]);
      norm_end_x_o     <= norm_out(sd.nzero[4], sd.nsat[4], quo[8]);
      norm_end_y_o     <= norm_out(sd.nzero[5], sd.nsat[5], quo[9]);
    end
  end

  assign out_valid_o = out_valid_q;

  // a collapsed box never leaves the block
  `CQS_ASSERT_IMP(a_no_collapsed, clk_i, rst_ni, out_valid_o,
                  (box_width_o != '0) || (box_height_o != '0), "collapsed box delivered")
  // a zero-width box gives zero normalized x coordinates
  `CQS_ASSERT_IMP(a_zero_w_norm, clk_i, rst_ni, out_valid_o && (box_width_o == '0),
                  (norm_start_x_o == '0) && (norm_control_x_o == '0) && (norm_end_x_o == '0),
                  "nonzero norm x on zero width")
  // a held result keeps the input side stalled
  `CQS_ASSERT_IMP(a_stall_back, clk_i, rst_ni, out_valid_o && out_stall_i, in_stall_o,
                  "input accepted while result held")

endmodule

/* design/cqs_bbox.sv */
// Input stage: thickened bounding box of one segment
`timescale 1ns / 1ps
module cqs_bbox import cqs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [15:0] start_x_i,
  input  logic signed [15:0] start_y_i,
  input  logic signed [15:0] control_x_i,
  input  logic signed [15:0] control_y_i,
  input  logic signed [15:0] end_x_i,
  input  logic signed [15:0] end_y_i,
  input  logic [11:0]        start_thickness_i,
  input  logic [11:0]        end_thickness_i,
  output logic               valid_o,
  output bbox_t              box_o
);

  logic        valid_q;
  bbox_t       box_q, box_d;
  logic [12:0] tsum;
  coord_t      t0, t2, tm;

  always_comb begin
    tsum = {1'b0, start_thickness_i} + {1'b0, end_thickness_i};
    t0   = coord_t'({6'b0, start_thickness_i});
    t2   = coord_t'({6'b0, end_thickness_i});
    tm   = coord_t'({6'b0, tsum[12:1]});
    box_d.sx   = start_x_i;
    box_d.sy   = start_y_i;
    box_d.cx   = control_x_i;
    box_d.cy   = control_y_i;
    box_d.ex   = end_x_i;
    box_d.ey   = end_y_i;
    box_d.lo_x = min3(18'(start_x_i) - t0, 18'(control_x_i) - tm, 18'(end_x_i) - t2);
    box_d.lo_y = min3(18'(start_y_i) - t0, 18'(control_y_i) - tm, 18'(end_y_i) - t2);
    box_d.hi_x = max3(18'(start_x_i) + t0, 18'(control_x_i) + tm, 18'(end_x_i) + t2);
    box_d.hi_y = max3(18'(start_y_i) + t0, 18'(control_y_i) + tm, 18'(end_y_i) + t2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      box_q <= box_d;
    end
  end

  assign valid_o = valid_q;
  assign box_o   = box_q;

endmodule

/* design/cqs_div.sv */
// Pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module cqs_div import cqs_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [16:0] rem_i,
  input  logic [16:0] den_i,
  input  logic [15:0] low_i,
  output logic [15:0] quo_o
);

  logic [16:0] rem_q [DivStages];
  logic [16:0] den_q [DivStages];
  logic [15:0] low_q [DivStages];
  logic [15:0] quo_q [DivStages];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= rem_i;
      den_q[0] <= den_i;
      low_q[0] <= low_i;
      quo_q[0] <= '0;
    end
  end

  for (genvar k = 1; k < DivStages; k++) begin : g_step
    logic [17:0] step;
    assign step = div_step(rem_q[k-1], den_q[k-1], low_q[k-1][15]);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= step[16:0];
        den_q[k] <= den_q[k-1];
        low_q[k] <= {low_q[k-1][14:0], 1'b0};
        quo_q[k] <= {quo_q[k-1][14:0], step[17]};
      end
    end
  end

  assign quo_o = quo_q[DivStages-1];

endmodule

/* dv/cqs_result_checker.sv */
// Checker for the curve segment quad setup: predicts each result and compares it
`timescale 1ns / 1ps
module cqs_result_checker import cqs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [12:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic signed [15:0] start_x_i,
  input  logic signed [15:0] start_y_i,
  input  logic signed [15:0] control_x_i,
  input  logic signed [15:0] control_y_i,
  input  logic signed [15:0] end_x_i,
  input  logic signed [15:0] end_y_i,
  input  logic [11:0]        start_thickness_i,
  input  logic [11:0]        end_thickness_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [15:0] quad_left_i,
  input  logic signed [15:0] quad_bottom_i,
  input  logic signed [15:0] quad_right_i,
  input  logic signed [15:0] quad_top_i,
  input  logic [16:0]        box_width_i,
  input  logic [16:0]        box_height_i,
  input  logic [15:0]        norm_start_x_i,
  input  logic [15:0]        norm_start_y_i,
  input  logic [15:0]        norm_control_x_i,
  input  logic [15:0]        norm_control_y_i,
  input  logic [15:0]        norm_end_x_i,
  input  logic [15:0]        norm_end_y_i,
  output int                 errors_o,
  output int                 pending_o
);

  typedef struct packed {
    logic [15:0]       left;
    logic [15:0]       bottom;
    logic [15:0]       right;
    logic [15:0]       top;
    logic [16:0]       w;
    logic [16:0]       h;
    logic [5:0][15:0]  norm;
  } quad_t;

  logic [12:0] width_q, height_q, off_x_q, off_y_q;
  quad_t       expected_quads[$];
  int          errors;

  assign errors_o  = errors;
  assign pending_o = expected_quads.size();

  function automatic logic [15:0] clip_edge(longint edge_v, logic [12:0] off,
                                            logic [12:0] sz);
    longint num, den, q;
    num = (longint'($signed(off)) * 16 + edge_v) * 32768;
    den = ((sz == 0) ? 1 : longint'(sz)) * 16;
    q = num / den;
    if (num % den != 0 && num < 0) q--;
    q -= 16384;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic logic [15:0] norm_point(longint p, longint lo, longint span);
    longint r;
    if (span <= 0) return 16'h0;
    r = ((p - lo) <<< 16) / span;
    return (r > 65535) ? 16'hFFFF : r[15:0];
  endfunction

  function automatic longint min3(longint a, longint b, longint c);
    longint m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic longint max3(longint a, longint b, longint c);
    longint m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 13'd1;
      height_q <= 13'd1;
      off_x_q  <= '0;
      off_y_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_i) begin
      case (cfg_index_i)
        RegContainerWidth:  width_q  <= cfg_data_i;
        RegContainerHeight: height_q <= cfg_data_i;
        RegContainerOffX:   off_x_q  <= cfg_data_i;
        RegContainerOffY:   off_y_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  initial errors = 0;

  // segment transfer: build the padded box and queue the expected quad
  always @(posedge clk_i) begin
    longint sx, sy, cx, cy, ex, ey, t0, t2, tm, lx, ly, hx, hy;
    quad_t  q;
    if (rst_ni && in_valid_i && !in_stall_i) begin
      sx = start_x_i;   sy = start_y_i;
      cx = control_x_i; cy = control_y_i;
      ex = end_x_i;     ey = end_y_i;
      t0 = start_thickness_i;
      t2 = end_thickness_i;
      tm = (t0 + t2) >>> 1;
      lx = min3(sx - t0, cx - tm, ex - t2);
      ly = min3(sy - t0, cy - tm, ey - t2);
      hx = max3(sx + t0, cx + tm, ex + t2);
      hy = max3(sy + t0, cy + tm, ey + t2);
      // collapsed box gives no result
      if (hx != lx || hy != ly) begin
        q.left    = clip_edge(lx, off_x_q, width_q);
        q.bottom  = clip_edge(ly, off_y_q, height_q);
        q.right   = clip_edge(hx, off_x_q, width_q);
        q.top     = clip_edge(hy, off_y_q, height_q);
        q.w       = 17'(hx - lx);
        q.h       = 17'(hy - ly);
        q.norm[0] = norm_point(sx, lx, hx - lx);
        q.norm[1] = norm_point(sy, ly, hy - ly);
        q.norm[2] = norm_point(cx, lx, hx - lx);
        q.norm[3] = norm_point(cy, ly, hy - ly);
        q.norm[4] = norm_point(ex, lx, hx - lx);
        q.norm[5] = norm_point(ey, ly, hy - ly);
        expected_quads.push_back(q);
      end
    end
  end

  always @(posedge clk_i) begin
    quad_t q;
    if (rst_ni && out_valid_i && !out_stall_i) begin
      if (expected_quads.size() == 0) begin
        $display("%0t: unexpected result, expected none, got left %0d", $time,
                 quad_left_i);
        errors++;
      end else begin
        q = expected_quads.pop_front();
        check_field("quad_left",      $signed(q.left),   quad_left_i);
        check_field("quad_bottom",    $signed(q.bottom), quad_bottom_i);
        check_field("quad_right",     $signed(q.right),  quad_right_i);
        check_field("quad_top",       $signed(q.top),    quad_top_i);
        check_field("box_width",      q.w,       box_width_i);
        check_field("box_height",     q.h,       box_height_i);
        check_field("norm_start_x",   q.norm[0], norm_start_x_i);
        check_field("norm_start_y",   q.norm[1], norm_start_y_i);
        check_field("norm_control_x", q.norm[2], norm_control_x_i);
        check_field("norm_control_y", q.norm[3], norm_control_y_i);
        check_field("norm_end_x",     q.norm[4], norm_end_x_i);
        check_field("norm_end_y",     q.norm[5], norm_end_y_i);
      end
    end
  end

endmodule

/* dv/tb.sv */
// Testbench top: stimulus, receiver stalls and verdict for the quad setup unit
`timescale 1ns / 1ps
module tb import cqs_pkg::*;;

  // pipeline is 19 deep; a dropped segment may still be in flight
  localparam int DrainCycles = 40;
  // longest quiet spell: largest input gap + largest receiver stall + pipeline, many times over
  localparam int QuietLimit  = 5000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = '0;
  logic [12:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [15:0] start_x_i = '0, start_y_i = '0;
  logic signed [15:0] control_x_i = '0, control_y_i = '0;
  logic signed [15:0] end_x_i = '0, end_y_i = '0;
  logic [11:0]        start_thickness_i = '0, end_thickness_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [15:0] quad_left_o, quad_bottom_o, quad_right_o, quad_top_o;
  logic [16:0]        box_width_o, box_height_o;
  logic [15:0]        norm_start_x_o, norm_start_y_o, norm_control_x_o;
  logic [15:0]        norm_control_y_o, norm_end_x_o, norm_end_y_o;

  int errors, pending;
  bit quiet_mode = 1'b0;  // no gaps and no stalls in this phase
  int stall_left = 0;
  int quiet_cycles = 0;

  curve_segment_quad_setup_unit dut (.*);

  cqs_result_checker checker_i (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i,
    .cfg_data_i, .in_valid_i, .in_stall_i(in_stall_o), .start_x_i, .start_y_i,
    .control_x_i, .control_y_i, .end_x_i, .end_y_i, .start_thickness_i,
    .end_thickness_i, .out_valid_i(out_valid_o), .out_stall_i,
    .quad_left_i(quad_left_o), .quad_bottom_i(quad_bottom_o),
    .quad_right_i(quad_right_o), .quad_top_i(quad_top_o),
    .box_width_i(box_width_o), .box_height_i(box_height_o),
    .norm_start_x_i(norm_start_x_o), .norm_start_y_i(norm_start_y_o),
    .norm_control_x_i(norm_control_x_o), .norm_control_y_i(norm_control_y_o),
    .norm_end_x_i(norm_end_x_o), .norm_end_y_i(norm_end_y_o),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Receiver: after each result transfer, draw a random stall, none in quiet mode.
  always @(posedge clk_i) begin
    int n;
    if (out_valid_o && !out_stall_i) begin
      n = quiet_mode ? 0 : $urandom_range(0, 13);
      stall_left  <= n;
      out_stall_i <= (n != 0);
    end else if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= (stall_left > 1);
    end
  end

  // Watchdog: any transfer on any channel resets the count.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [12:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Wait for all queued results, then let any dropped segments drain.
  task automatic drain_pipe();
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_container(logic [12:0] w, logic [12:0] h,
                               logic [12:0] ox, logic [12:0] oy);
    write_reg(RegContainerWidth, w);
    write_reg(RegContainerHeight, h);
    write_reg(RegContainerOffX, ox);
    write_reg(RegContainerOffY, oy);
  endtask

  // One segment transfer; valid stays high across back-to-back segments.
  task automatic send_segment(logic [15:0] sx, logic [15:0] sy, logic [15:0] cx,
                              logic [15:0] cy, logic [15:0] ex, logic [15:0] ey,
                              logic [11:0] t0, logic [11:0] t2);
    int gap;
    gap = quiet_mode ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    start_x_i         <= sx;
    start_y_i         <= sy;
    control_x_i       <= cx;
    control_y_i       <= cy;
    end_x_i           <= ex;
    end_y_i           <= ey;
    start_thickness_i <= t0;
    end_thickness_i   <= t2;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic stop_sending();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly clustered segments (realistic boxes), some full-range noise,
  // a few collapsed points and flat single-axis boxes.
  task automatic send_random_segment();
    logic [15:0] bx, by;
    int          span, kind;
    logic [11:0] t0, t2;
    kind = $urandom_range(0, 99);
    bx = 16'($urandom);
    by = 16'($urandom);
    if (kind < 20) begin
      send_segment(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom), 12'($urandom), 12'($urandom));
    end else if (kind < 24) begin
      send_segment(bx, by, bx, by, bx, by, 12'd0, 12'd0);
    end else if (kind < 30) begin
      send_segment(bx, by, 16'(bx + $urandom_range(0, 300)), by,
                   16'(bx - $urandom_range(0, 300)), by, 12'd0, 12'd0);
    end else begin
      span = (kind < 90) ? 511 : 8191;
      t0 = (kind < 60) ? 12'($urandom_range(0, 63)) : 12'($urandom);
      t2 = (kind < 60) ? 12'($urandom_range(0, 63)) : 12'($urandom);
      send_segment(bx, by,
                   16'(bx + $urandom_range(0, span)), 16'(by + $urandom_range(0, span)),
                   16'(bx - $urandom_range(0, span)), 16'(by - $urandom_range(0, span)),
                   t0, t2);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed segments under reset register values
    send_segment(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                 12'd0, 12'd0);
    send_segment(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                 12'd0, 12'd0);
    send_segment(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF,
                 12'hFFF, 12'hFFF);
    send_segment(16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'h8000, 16'h7FFF,
                 12'hFFF, 12'h000);
    // odd sum, mean rounds down
    send_segment(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 12'd0, 12'h001);
    // collapsed
    send_segment(16'd100, 16'd50, 16'd100, 16'd50, 16'd100, 16'd50, 12'd0, 12'd0);
    // flat in y
    send_segment(16'd10, 16'd50, 16'd200, 16'd50, -16'sd40, 16'd50, 12'd0, 12'd0);
    // flat in x
    send_segment(16'd30, -16'sd20, 16'd30, 16'd90, 16'd30, 16'd7, 12'd0, 12'd0);
    // diagonal, thickened at both ends
    send_segment(16'd0, 16'd0, 16'd16, 16'd16, 16'd32, 16'd32, 12'd5, 12'd7);
    send_segment(-16'sd5, 16'd3, 16'd1, 16'd2, 16'd4, -16'sd8, 12'h000, 12'hFFF);
    send_segment(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 16'h1234, 16'hEDCB,
                 12'hAAA, 12'h555);
    stop_sending();
    drain_pipe();

    // extreme container settings, including a zero size read as one
    set_container(13'd4096, 13'd4096, 13'h1000, 13'h0FFF);
    send_segment(16'h8000, 16'h7FFF, 16'd0, 16'd0, 16'h7FFF, 16'h8000, 12'hFFF, 12'hFFF);
    send_segment(16'd0, 16'd0, 16'd16, 16'd16, 16'd32, 16'd32, 12'd0, 12'd0);
    stop_sending();
    drain_pipe();
    set_container(13'd0, 13'd0, 13'h0FFF, 13'h1000);
    send_segment(16'd1, 16'd1, 16'd2, 16'd3, -16'sd4, 16'd5, 12'd1, 12'd2);
    stop_sending();
    drain_pipe();

    for (int phase = 0; phase < 8; phase++) begin
      quiet_mode = (phase % 3 == 2);
      case (phase)
        0: set_container(13'd1, 13'd1, 13'd0, 13'd0);
        1: set_container(13'd4096, 13'd4096, 13'h1000, 13'h1000);
        2: set_container(13'd1920, 13'd1080, 13'd0, 13'd0);
        3: set_container(13'd4096, 13'd1, 13'h0FFF, 13'h1000);
        4: set_container(13'd0, 13'd8191, 13'd12, 13'h1FF0);
        default: set_container(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)),
                               13'($urandom), 13'($urandom));
      endcase
      for (int i = 0; i < 210; i++) send_random_segment();
      stop_sending();
      drain_pipe();
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
